// File: rtl/vc_pkg.sv
package vc_pkg;

    localparam int NUM_SLOTS   = 4;
    localparam int SLOT_W      = 2;
    localparam int PRICE_W     = 16;
    localparam int STOCK_W     = 8;
    localparam int TOTAL_W     = 20;
    localparam int QUARTER_W   = 16;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 25;
    localparam int PROD_W      = TOTAL_W + RECIP_W;
    localparam int REM_W       = 5;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [STOCK_W-1:0] STOCK_MAX = 8'd255;

    localparam logic [TOTAL_W-1:0] CENTS_NICKEL  = 20'd5;
    localparam logic [TOTAL_W-1:0] CENTS_DIME    = 20'd10;
    localparam logic [TOTAL_W-1:0] CENTS_QUARTER = 20'd25;
    localparam logic [TOTAL_W-1:0] CENTS_ONE     = 20'd100;
    localparam logic [TOTAL_W-1:0] CENTS_FIVE    = 20'd500;
    localparam logic [TOTAL_W-1:0] CENTS_TEN     = 20'd1000;
    localparam logic [TOTAL_W-1:0] CENTS_TWENTY  = 20'd2000;

    // ceil(2^25 / 25): exact quotient for every total below 2^20
    localparam logic [RECIP_W-1:0] RECIP_25 = 21'd1342178;

    typedef enum logic [1:0] {
        REQ_SELECT  = 2'd0,
        REQ_PAY     = 2'd1,
        REQ_CANCEL  = 2'd2,
        REQ_RESTOCK = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NO_STOCK  = 3'd3,
        ST_BAD_STATE = 3'd4,
        ST_SHORT     = 3'd5
    } status_t;

    typedef enum logic {
        MODE_IDLE      = 1'b0,
        MODE_SELECTING = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        REG_PRICE_SLOT0 = 2'd0,
        REG_PRICE_SLOT1 = 2'd1,
        REG_PRICE_SLOT2 = 2'd2,
        REG_PRICE_SLOT3 = 2'd3
    } reg_idx_t;

    typedef logic [NUM_SLOTS-1:0][PRICE_W-1:0] price_arr_t;

    typedef struct packed {
        status_t             status;
        logic [PRICE_W-1:0]  shown_price;
        logic                dispensed;
        logic [SLOT_W-1:0]   dispensed_slot;
        mode_t               mode_now;
    } res_t;

endpackage

// File: rtl/vc_regs.sv
module vc_regs
    import vc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output price_arr_t        prices
);

    price_arr_t price_reg;
    reg_idx_t   idx;
    logic       wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prices = price_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            price_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_PRICE_SLOT0: price_reg[0] <= pwdata[PRICE_W-1:0];
                REG_PRICE_SLOT1: price_reg[1] <= pwdata[PRICE_W-1:0];
                REG_PRICE_SLOT2: price_reg[2] <= pwdata[PRICE_W-1:0];
                REG_PRICE_SLOT3: price_reg[3] <= pwdata[PRICE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = {{(DATA_W-PRICE_W){1'b0}}, price_reg[idx]};
    end

endmodule

// File: rtl/vc_core.sv
module vc_core
    import vc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [2:0]         s_slot,
    input  logic [7:0]         s_restock_qty,
    input  logic [7:0]         s_pay_pennies,
    input  logic [7:0]         s_pay_nickels,
    input  logic [7:0]         s_pay_dimes,
    input  logic [7:0]         s_pay_quarters,
    input  logic [7:0]         s_pay_ones,
    input  logic [7:0]         s_pay_fives,
    input  logic [7:0]         s_pay_tens,
    input  logic [7:0]         s_pay_twenties,
    input  price_arr_t         prices,
    output logic               mid_valid,
    input  logic               mid_ready,
    output res_t               mid_res,
    output logic [TOTAL_W-1:0] mid_rem,
    output logic               in_full
);

    logic                  in_valid_reg;
    req_t                  req_reg;
    logic [2:0]            slot_reg;
    logic [STOCK_W-1:0]    qty_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_in;

    logic [NUM_SLOTS-1:0][STOCK_W-1:0] stock_reg;
    logic [SLOT_W-1:0]     sel_reg;
    logic [SLOT_W-1:0]     sel_next;
    mode_t                 mode_reg;
    mode_t                 mode_next;

    logic                  adv;
    logic [SLOT_W-1:0]     idx;
    logic [PRICE_W-1:0]    price_rd;
    logic [STOCK_W-1:0]    stock_rd;
    logic [STOCK_W-1:0]    stock_wr;
    logic [STOCK_W-1:0]    room;
    logic                  stock_wen;

    assign adv       = in_valid_reg && mid_ready;
    assign s_ready   = !in_valid_reg || mid_ready;
    assign mid_valid = in_valid_reg;
    assign in_full   = in_valid_reg;

    assign total_in = TOTAL_W'(s_pay_pennies)
                    + TOTAL_W'(s_pay_nickels)  * CENTS_NICKEL
                    + TOTAL_W'(s_pay_dimes)    * CENTS_DIME
                    + TOTAL_W'(s_pay_quarters) * CENTS_QUARTER
                    + TOTAL_W'(s_pay_ones)     * CENTS_ONE
                    + TOTAL_W'(s_pay_fives)    * CENTS_FIVE
                    + TOTAL_W'(s_pay_tens)     * CENTS_TEN
                    + TOTAL_W'(s_pay_twenties) * CENTS_TWENTY;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg   <= req_t'(s_req_type);
            slot_reg  <= s_slot;
            qty_reg   <= s_restock_qty;
            total_reg <= total_in;
        end
    end

    assign idx      = (req_reg == REQ_PAY) ? sel_reg : slot_reg[SLOT_W-1:0];
    assign price_rd = prices[idx];
    assign stock_rd = stock_reg[idx];
    assign room     = STOCK_MAX - stock_rd;

    always_comb begin
        mid_res.status         = ST_OK;
        mid_res.shown_price    = '0;
        mid_res.dispensed      = 1'b0;
        mid_res.dispensed_slot = '0;
        mid_rem                = '0;
        mode_next              = mode_reg;
        sel_next               = sel_reg;
        stock_wr               = stock_rd;
        stock_wen              = 1'b0;
        unique case (req_reg)
            REQ_SELECT: begin
                if (mode_reg != MODE_IDLE) begin
                    mid_res.status = ST_BUSY;
                end else if (slot_reg[2]) begin
                    mid_res.status = ST_NOT_FOUND;
                end else if (stock_rd == '0) begin
                    mid_res.status = ST_NO_STOCK;
                end else begin
                    sel_next            = slot_reg[SLOT_W-1:0];
                    mode_next           = MODE_SELECTING;
                    mid_res.shown_price = price_rd;
                end
            end
            REQ_PAY: begin
                if (mode_reg != MODE_SELECTING) begin
                    mid_res.status = ST_BAD_STATE;
                end else if (total_reg < TOTAL_W'(price_rd)) begin
                    mid_res.status = ST_SHORT;
                end else begin
                    mid_rem                = total_reg - TOTAL_W'(price_rd);
                    stock_wen              = (stock_rd != '0);
                    stock_wr               = stock_rd - STOCK_W'(1);
                    mid_res.dispensed      = 1'b1;
                    mid_res.dispensed_slot = sel_reg;
                    mode_next              = MODE_IDLE;
                    sel_next               = '0;
                end
            end
            REQ_CANCEL: begin
                mode_next = MODE_IDLE;
                sel_next  = '0;
            end
            REQ_RESTOCK: begin
                if (slot_reg[2]) begin
                    mid_res.status = ST_NOT_FOUND;
                end else begin
                    stock_wen = 1'b1;
                    stock_wr  = (qty_reg >= room) ? STOCK_MAX : stock_rd + qty_reg;
                end
            end
            default: ;
        endcase
        mid_res.mode_now = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stock_reg <= '0;
            sel_reg   <= '0;
            mode_reg  <= MODE_IDLE;
        end else if (adv) begin
            sel_reg  <= sel_next;
            mode_reg <= mode_next;
            if (stock_wen) begin
                stock_reg[idx] <= stock_wr;
            end
        end
    end

endmodule

// File: rtl/vc_change.sv
module vc_change
    import vc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 mid_valid,
    output logic                 mid_ready,
    input  res_t                 mid_res,
    input  logic [TOTAL_W-1:0]   mid_rem,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [PRICE_W-1:0]   m_shown_price,
    output logic                 m_dispensed,
    output logic [SLOT_W-1:0]    m_dispensed_slot,
    output logic [QUARTER_W-1:0] m_change_quarters,
    output logic [1:0]           m_change_dimes,
    output logic                 m_change_nickels,
    output logic [2:0]           m_change_pennies,
    output logic                 m_mode_now
);

    logic                 v1_reg;
    res_t                 res1_reg;
    logic [TOTAL_W-1:0]   rem1_reg;
    logic                 ready1;

    logic                 v2_reg;
    res_t                 res2_reg;
    logic [TOTAL_W-1:0]   rem2_reg;
    logic [PROD_W-1:0]    prod2_reg;
    logic                 ready2;

    logic                 out_valid_reg;
    res_t                 out_res_reg;
    logic [QUARTER_W-1:0] cq_reg;
    logic [1:0]           cd_reg;
    logic                 cn_reg;
    logic [2:0]           cp_reg;
    logic                 out_ready;

    logic [PROD_W-1:0]    prod_next;
    logic [QUARTER_W-1:0] cq_next;
    logic [REM_W-1:0]     r25;
    logic [REM_W-1:0]     r10;
    logic [1:0]           cd_next;
    logic                 cn_next;
    logic [2:0]           cp_next;

    assign out_ready = !out_valid_reg || m_ready;
    assign ready2    = !v2_reg || out_ready;
    assign ready1    = !v1_reg || ready2;
    assign mid_ready = ready1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= mid_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (out_ready) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    assign prod_next = PROD_W'(rem1_reg) * PROD_W'(RECIP_25);

    assign cq_next = prod2_reg[RECIP_SHIFT +: QUARTER_W];
    assign r25     = REM_W'(rem2_reg - TOTAL_W'(cq_next) * CENTS_QUARTER);

    always_comb begin
        if (r25 >= REM_W'(20)) begin
            cd_next = 2'd2;
            r10     = r25 - REM_W'(20);
        end else if (r25 >= REM_W'(10)) begin
            cd_next = 2'd1;
            r10     = r25 - REM_W'(10);
        end else begin
            cd_next = 2'd0;
            r10     = r25;
        end
        cn_next = (r10 >= REM_W'(5));
        cp_next = cn_next ? 3'(r10 - REM_W'(5)) : 3'(r10);
    end

    always_ff @(posedge aclk) begin
        if (mid_valid && ready1) begin
            res1_reg <= mid_res;
            rem1_reg <= mid_rem;
        end
        if (v1_reg && ready2) begin
            res2_reg  <= res1_reg;
            rem2_reg  <= rem1_reg;
            prod2_reg <= prod_next;
        end
        if (v2_reg && out_ready) begin
            out_res_reg <= res2_reg;
            cq_reg      <= cq_next;
            cd_reg      <= cd_next;
            cn_reg      <= cn_next;
            cp_reg      <= cp_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = out_res_reg.status;
    assign m_shown_price     = out_res_reg.shown_price;
    assign m_dispensed       = out_res_reg.dispensed;
    assign m_dispensed_slot  = out_res_reg.dispensed_slot;
    assign m_mode_now        = out_res_reg.mode_now;
    assign m_change_quarters = cq_reg;
    assign m_change_dimes    = cd_reg;
    assign m_change_nickels  = cn_reg;
    assign m_change_pennies  = cp_reg;

endmodule

// File: rtl/vending_controller.sv
// Vending controller, four slots, money in integer cents.
// Path: a request passes the input register (decision and state update), a capture register,
// the change multiply register and the output register.
// Throughput: one request per cycle while m_ready holds; state is updated in the decision stage.
// Reset (aresetn low, synchronous): stock, selection, mode and prices clear to zero.
module vending_controller
    import vc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [2:0]           s_slot,
    input  logic [7:0]           s_restock_qty,
    input  logic [7:0]           s_pay_pennies,
    input  logic [7:0]           s_pay_nickels,
    input  logic [7:0]           s_pay_dimes,
    input  logic [7:0]           s_pay_quarters,
    input  logic [7:0]           s_pay_ones,
    input  logic [7:0]           s_pay_fives,
    input  logic [7:0]           s_pay_tens,
    input  logic [7:0]           s_pay_twenties,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [PRICE_W-1:0]   m_shown_price,
    output logic                 m_dispensed,
    output logic [SLOT_W-1:0]    m_dispensed_slot,
    output logic [QUARTER_W-1:0] m_change_quarters,
    output logic [1:0]           m_change_dimes,
    output logic                 m_change_nickels,
    output logic [2:0]           m_change_pennies,
    output logic                 m_mode_now
);

    price_arr_t         prices;
    logic               mid_valid;
    logic               mid_ready;
    res_t               mid_res;
    logic [TOTAL_W-1:0] mid_rem;
    logic               in_full;

    vc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .prices  (prices)
    );

    vc_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_slot         (s_slot),
        .s_restock_qty  (s_restock_qty),
        .s_pay_pennies  (s_pay_pennies),
        .s_pay_nickels  (s_pay_nickels),
        .s_pay_dimes    (s_pay_dimes),
        .s_pay_quarters (s_pay_quarters),
        .s_pay_ones     (s_pay_ones),
        .s_pay_fives    (s_pay_fives),
        .s_pay_tens     (s_pay_tens),
        .s_pay_twenties (s_pay_twenties),
        .prices         (prices),
        .mid_valid      (mid_valid),
        .mid_ready      (mid_ready),
        .mid_res        (mid_res),
        .mid_rem        (mid_rem),
        .in_full        (in_full)
    );

    vc_change u_change (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .mid_valid         (mid_valid),
        .mid_ready         (mid_ready),
        .mid_res           (mid_res),
        .mid_rem           (mid_rem),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_shown_price     (m_shown_price),
        .m_dispensed       (m_dispensed),
        .m_dispensed_slot  (m_dispensed_slot),
        .m_change_quarters (m_change_quarters),
        .m_change_dimes    (m_change_dimes),
        .m_change_nickels  (m_change_nickels),
        .m_change_pennies  (m_change_pennies),
        .m_mode_now        (m_mode_now)
    );

`ifndef SYNTHESIS
    a_transfer_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_full)
        else $error("accepted request not held in input stage");

    a_dispense_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dispensed |-> m_status == ST_OK && m_mode_now == MODE_IDLE
                                    && m_shown_price == '0)
        else $error("dispense with bad status, mode or price");

    a_change_needs_dispense: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_change_quarters != '0 || m_change_dimes != '0
                    || m_change_nickels || m_change_pennies != '0) |-> m_dispensed)
        else $error("change returned without dispense");
`endif

endmodule
